@@ src/mffs_pkg.sv @@
// Shared types and constants for the maze flood-fill solver.
// Used by the controller, queue, top level and checker; depends on nothing.
package mffs_pkg;

  typedef struct packed {
    logic       operation;
    logic [3:0] cell_row;
    logic [3:0] cell_column;
    logic [1:0] heading;
    logic       wall_right;
    logic       wall_left;
    logic       wall_front;
  } in_item_t;

  typedef struct packed {
    logic [1:0] next_direction;
    logic [7:0] cell_distance;
    logic       queue_overflow;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } queue_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WSELF, ST_WNB, ST_WNBW, ST_FSTART, ST_POP,
    ST_PCELL, ST_CWALL, ST_NRD, ST_NCMP, ST_AFTER, ST_OWN, ST_PUSH
  } state_t;

  localparam logic       OP_INIT  = 1'b0;
  localparam logic       OP_VISIT = 1'b1;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [1:0] CFG_ROWS     = 2'd0;
  localparam logic [1:0] CFG_COLUMNS  = 2'd1;
  localparam logic [1:0] CFG_GOAL_ROW = 2'd2;
  localparam logic [1:0] CFG_GOAL_COL = 2'd3;

  localparam logic [4:0] ROWS_RESET     = 5'd16;
  localparam logic [4:0] COLUMNS_RESET  = 5'd16;
  localparam logic [3:0] GOAL_ROW_RESET = 4'd7;
  localparam logic [3:0] GOAL_COL_RESET = 4'd7;

  localparam logic [7:0] DIST_NONE = 8'd255;
  localparam logic [7:0] DIST_MAX  = 8'd254;

  // Neighbor order for the lowest-distance pick: N, W, E, S.
  function automatic logic [1:0] scan_dir(input logic [1:0] k);
    logic [1:0] d;
    case (k)
      2'd0: d = DIR_N;
      2'd1: d = DIR_W;
      2'd2: d = DIR_E;
      default: d = DIR_S;
    endcase
    return d;
  endfunction

  // Neighbor order for queueing after a raise: N, S, E, W.
  function automatic logic [1:0] push_dir(input logic [1:0] k);
    logic [1:0] d;
    case (k)
      2'd0: d = DIR_N;
      2'd1: d = DIR_S;
      2'd2: d = DIR_E;
      default: d = DIR_W;
    endcase
    return d;
  endfunction

endpackage

@@ src/mffs_grid.sv @@
// Cell store: wall bits and distance of every cell, one port pair each.
// Depends on nothing beyond its parameters.
module mffs_grid #(
  parameter int CELLW = 8
) (
  input  logic             clk,
  input  logic [CELLW-1:0] wall_ra,
  input  logic             wall_we,
  input  logic [CELLW-1:0] wall_wa,
  input  logic [3:0]       wall_wd,
  output logic [3:0]       wall_q,
  input  logic [CELLW-1:0] dist_ra,
  input  logic             dist_we,
  input  logic [CELLW-1:0] dist_wa,
  input  logic [7:0]       dist_wd,
  output logic [7:0]       dist_q
);

  logic [3:0] wall_mem [2**CELLW];
  logic [7:0] dist_mem [2**CELLW];

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_wa] <= wall_wd;
    end
    wall_q <= wall_mem[wall_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_q <= dist_mem[dist_ra];
  end

endmodule

@@ src/mffs_queue.sv @@
// Circular flood queue of cell addresses with head, count and overflow flag.
// Depends on mffs_pkg for the command struct.
module mffs_queue #(
  parameter int QUEUE_DEPTH = 512,
  parameter int CELLW       = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mffs_pkg::queue_cmd_t cmd,
  input  logic [CELLW-1:0]    wdata,
  output logic [CELLW-1:0]    rdata,
  output logic                empty,
  output logic                overflow
);

  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = $clog2(2 * QUEUE_DEPTH);

  logic [CELLW-1:0] mem [QUEUE_DEPTH];
  logic [QW-1:0]    head_r, head_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SW-1:0]    sum;
  logic [QW-1:0]    waddr;
  logic             full;
  logic             do_write;

  assign full  = (count_r == CNTW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign overflow = ovf_r;
  assign sum   = SW'(head_r) + SW'(count_r);
  assign waddr = (sum >= SW'(QUEUE_DEPTH)) ? QW'(sum - SW'(QUEUE_DEPTH)) : QW'(sum);
  assign do_write = cmd.push && !full;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.push) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (cmd.pop && !empty) begin
      head_nxt  = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[head_r];
  end

endmodule

@@ src/mffs_ctrl.sv @@
// Sequencer of the solver: grid rebuild sweep, wall marking, flood-fill loop
// and the shared neighbor/compare unit. Depends on mffs_pkg.
module mffs_ctrl #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  mffs_pkg::in_item_t    in_item,
  output logic                  busy,
  output logic                  out_valid,
  output mffs_pkg::out_item_t   out_item,
  input  logic [$clog2(MAX_ROWS):0]    rows_eff,
  input  logic [$clog2(MAX_COLUMNS):0] cols_eff,
  input  logic [3:0]            goal_row,
  input  logic [3:0]            goal_col,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] wall_ra,
  output logic                  wall_we,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] wall_wa,
  output logic [3:0]            wall_wd,
  input  logic [3:0]            wall_q,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] dist_ra,
  output logic                  dist_we,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] dist_wa,
  output logic [7:0]            dist_wd,
  input  logic [7:0]            dist_q,
  output mffs_pkg::queue_cmd_t  q_cmd,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] q_wdata,
  input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] q_rdata,
  input  logic                  q_empty,
  input  logic                  q_overflow
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int CELLW = RW + CW;

  mffs_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]    row_r, row_nxt, vrow_r, vrow_nxt;
  logic [CW-1:0]    col_r, col_nxt, vcol_r, vcol_nxt;
  logic [1:0]       head_r, head_nxt;
  logic [2:0]       sens_r, sens_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [3:0]       cwall_r, cwall_nxt;
  logic [7:0]       best_r, best_nxt;
  logic [1:0]       dir_r, dir_nxt;
  logic [7:0]       nv_r, nv_nxt;
  logic             final_r, final_nxt;
  logic             rep_r, rep_nxt;
  logic [CELLW-1:0] addr_r, addr_nxt;
  logic             ov_r, ov_nxt;
  mffs_pkg::out_item_t oi_r, oi_nxt;

  // Shared neighbor unit: one direction per cycle from the current cell.
  logic [1:0]       nb_dir;
  logic             nb_ok;
  logic [RW-1:0]    nb_row;
  logic [CW-1:0]    nb_col;
  logic [CELLW-1:0] nb_addr, cur_addr;
  logic [1:0]       sdir;

  // Rebuild sweep cell values.
  logic [RW-1:0]    sw_row;
  logic [CW-1:0]    sw_col;
  logic [7:0]       dr, dc, dsum;
  logic             sw_in;
  logic [3:0]       sw_wall;

  assign cur_addr = {row_r, col_r};
  assign nb_addr  = {nb_row, nb_col};
  assign busy     = (state_r != mffs_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_comb begin
    case (k_r)
      2'd0: sdir = head_r + 2'd1;
      2'd1: sdir = head_r + 2'd3;
      default: sdir = head_r;
    endcase
  end

  always_comb begin
    case (state_r)
      mffs_pkg::ST_NRD, mffs_pkg::ST_NCMP: nb_dir = mffs_pkg::scan_dir(k_r);
      mffs_pkg::ST_PUSH: nb_dir = mffs_pkg::push_dir(k_r);
      default: nb_dir = sdir;
    endcase
  end

  always_comb begin
    nb_row = row_r;
    nb_col = col_r;
    case (nb_dir)
      mffs_pkg::DIR_N: begin
        nb_ok  = ({1'b0, row_r} + 1'b1) < rows_eff;
        nb_row = row_r + 1'b1;
      end
      mffs_pkg::DIR_E: begin
        nb_ok  = ({1'b0, col_r} + 1'b1) < cols_eff;
        nb_col = col_r + 1'b1;
      end
      mffs_pkg::DIR_S: begin
        nb_ok  = (row_r != '0);
        nb_row = row_r - 1'b1;
      end
      default: begin
        nb_ok  = (col_r != '0);
        nb_col = col_r - 1'b1;
      end
    endcase
  end

  always_comb begin
    sw_row = addr_r[CELLW-1:CW];
    sw_col = addr_r[CW-1:0];
    sw_in  = ({1'b0, sw_row} < rows_eff) && ({1'b0, sw_col} < cols_eff);
    dr = (8'(sw_row) > 8'(goal_row)) ? 8'(sw_row) - 8'(goal_row)
                                     : 8'(goal_row) - 8'(sw_row);
    dc = (8'(sw_col) > 8'(goal_col)) ? 8'(sw_col) - 8'(goal_col)
                                     : 8'(goal_col) - 8'(sw_col);
    dsum = dr + dc;
    sw_wall = 4'b0000;
    if (sw_row == '0) begin
      sw_wall[mffs_pkg::DIR_S] = 1'b1;
      // The start cell also gets an east wall.
      if (sw_col == '0) sw_wall[mffs_pkg::DIR_E] = 1'b1;
    end
    if ({1'b0, sw_row} == rows_eff - 1'b1) sw_wall[mffs_pkg::DIR_N] = 1'b1;
    if (sw_col == '0) sw_wall[mffs_pkg::DIR_W] = 1'b1;
    if ({1'b0, sw_col} == cols_eff - 1'b1) sw_wall[mffs_pkg::DIR_E] = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;  col_nxt = col_r;
    vrow_nxt = vrow_r;  vcol_nxt = vcol_r;
    head_nxt = head_r;  sens_nxt = sens_r;
    k_nxt = k_r;  cwall_nxt = cwall_r;
    best_nxt = best_r;  dir_nxt = dir_r;  nv_nxt = nv_r;
    final_nxt = final_r;  rep_nxt = rep_r;  addr_nxt = addr_r;
    ov_nxt = 1'b0;  oi_nxt = oi_r;
    wall_ra = cur_addr;  wall_we = 1'b0;  wall_wa = cur_addr;  wall_wd = cwall_r;
    dist_ra = cur_addr;  dist_we = 1'b0;  dist_wa = cur_addr;  dist_wd = nv_r;
    q_cmd = '0;  q_wdata = cur_addr;

    case (state_r)
      mffs_pkg::ST_CLEAR: begin
        wall_we = 1'b1;  wall_wa = addr_r;  wall_wd = sw_in ? sw_wall : 4'b0000;
        dist_we = 1'b1;  dist_wa = addr_r;
        dist_wd = !sw_in ? mffs_pkg::DIST_NONE
                : (dsum > mffs_pkg::DIST_MAX) ? mffs_pkg::DIST_MAX : dsum;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == '1) begin
          state_nxt = mffs_pkg::ST_IDLE;
          q_cmd.clear = 1'b1;
          if (rep_r) begin
            ov_nxt = 1'b1;
            oi_nxt = '{mffs_pkg::DIR_N, mffs_pkg::DIST_NONE, 1'b0};
          end
        end
      end
      mffs_pkg::ST_IDLE: begin
        wall_ra = {RW'(in_item.cell_row), CW'(in_item.cell_column)};
        if (start) begin
          if (in_item.operation == mffs_pkg::OP_INIT) begin
            addr_nxt = '0;
            rep_nxt = 1'b1;
            state_nxt = mffs_pkg::ST_CLEAR;
          end else if (8'(in_item.cell_row) >= 8'(rows_eff) ||
                       8'(in_item.cell_column) >= 8'(cols_eff)) begin
            ov_nxt = 1'b1;
            oi_nxt = '{mffs_pkg::DIR_N, mffs_pkg::DIST_NONE, 1'b0};
          end else begin
            row_nxt  = RW'(in_item.cell_row);
            col_nxt  = CW'(in_item.cell_column);
            vrow_nxt = RW'(in_item.cell_row);
            vcol_nxt = CW'(in_item.cell_column);
            head_nxt = in_item.heading;
            sens_nxt = {in_item.wall_front, in_item.wall_left, in_item.wall_right};
            final_nxt = 1'b0;
            q_cmd.clear = 1'b1;
            state_nxt = mffs_pkg::ST_WSELF;
          end
        end
      end
      mffs_pkg::ST_WSELF: begin
        // Open the wall behind, then set the sensed ones on this cell.
        wall_we = 1'b1;
        wall_wd = (wall_q & ~(4'b0001 << (head_r + 2'd2)))
                | (sens_r[0] ? (4'b0001 << (head_r + 2'd1)) : 4'b0000)
                | (sens_r[1] ? (4'b0001 << (head_r + 2'd3)) : 4'b0000)
                | (sens_r[2] ? (4'b0001 << head_r) : 4'b0000);
        k_nxt = 2'd0;
        state_nxt = mffs_pkg::ST_WNB;
      end
      mffs_pkg::ST_WNB: begin
        wall_ra = nb_addr;
        if (sens_r[k_r] && nb_ok) begin
          state_nxt = mffs_pkg::ST_WNBW;
        end else if (k_r == 2'd2) begin
          state_nxt = mffs_pkg::ST_FSTART;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      mffs_pkg::ST_WNBW: begin
        wall_we = 1'b1;
        wall_wa = nb_addr;
        wall_wd = wall_q | (4'b0001 << (nb_dir + 2'd2));
        if (k_r == 2'd2) begin
          state_nxt = mffs_pkg::ST_FSTART;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = mffs_pkg::ST_WNB;
        end
      end
      mffs_pkg::ST_FSTART: begin
        q_cmd.push = 1'b1;
        state_nxt = mffs_pkg::ST_POP;
      end
      mffs_pkg::ST_POP: begin
        if (q_empty) begin
          row_nxt = vrow_r;
          col_nxt = vcol_r;
          wall_ra = {vrow_r, vcol_r};
          final_nxt = 1'b1;
          state_nxt = mffs_pkg::ST_CWALL;
        end else begin
          q_cmd.pop = 1'b1;
          state_nxt = mffs_pkg::ST_PCELL;
        end
      end
      mffs_pkg::ST_PCELL: begin
        row_nxt = q_rdata[CELLW-1:CW];
        col_nxt = q_rdata[CW-1:0];
        wall_ra = q_rdata;
        // The goal cell keeps its distance.
        if (8'(q_rdata[CELLW-1:CW]) == 8'(goal_row) &&
            8'(q_rdata[CW-1:0]) == 8'(goal_col)) begin
          state_nxt = mffs_pkg::ST_POP;
        end else begin
          state_nxt = mffs_pkg::ST_CWALL;
        end
      end
      mffs_pkg::ST_CWALL: begin
        cwall_nxt = wall_q;
        k_nxt = 2'd0;
        best_nxt = mffs_pkg::DIST_NONE;
        dir_nxt = mffs_pkg::DIR_N;
        state_nxt = mffs_pkg::ST_NRD;
      end
      mffs_pkg::ST_NRD: begin
        dist_ra = nb_addr;
        if (!cwall_r[nb_dir] && nb_ok) begin
          state_nxt = mffs_pkg::ST_NCMP;
        end else if (k_r == 2'd3) begin
          state_nxt = mffs_pkg::ST_AFTER;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      mffs_pkg::ST_NCMP: begin
        if (dist_q < best_r) begin
          best_nxt = dist_q;
          dir_nxt = nb_dir;
        end
        if (k_r == 2'd3) begin
          state_nxt = mffs_pkg::ST_AFTER;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = mffs_pkg::ST_NRD;
        end
      end
      mffs_pkg::ST_AFTER: begin
        nv_nxt = (best_r >= mffs_pkg::DIST_MAX) ? mffs_pkg::DIST_MAX : best_r + 1'b1;
        state_nxt = mffs_pkg::ST_OWN;
      end
      mffs_pkg::ST_OWN: begin
        if (final_r) begin
          ov_nxt = 1'b1;
          oi_nxt = '{dir_r, dist_q, q_overflow};
          state_nxt = mffs_pkg::ST_IDLE;
        end else if (nv_r > dist_q) begin
          dist_we = 1'b1;
          k_nxt = 2'd0;
          state_nxt = mffs_pkg::ST_PUSH;
        end else begin
          state_nxt = mffs_pkg::ST_POP;
        end
      end
      mffs_pkg::ST_PUSH: begin
        q_wdata = nb_addr;
        q_cmd.push = !cwall_r[nb_dir] && nb_ok;
        if (k_r == 2'd3) begin
          state_nxt = mffs_pkg::ST_POP;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = mffs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mffs_pkg::ST_CLEAR;
      addr_r  <= '0;
      rep_r   <= 1'b0;
      ov_r    <= 1'b0;
      k_r     <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      rep_r   <= rep_nxt;
      ov_r    <= ov_nxt;
      k_r     <= k_nxt;
      final_r <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    vrow_r  <= vrow_nxt;
    vcol_r  <= vcol_nxt;
    head_r  <= head_nxt;
    sens_r  <= sens_nxt;
    cwall_r <= cwall_nxt;
    best_r  <= best_nxt;
    dir_r   <= dir_nxt;
    nv_r    <= nv_nxt;
    oi_r    <= oi_nxt;
  end

endmodule

@@ src/maze_floodfill_solver_top.sv @@
// Maze flood-fill solver: after reset the block rebuilds its grid, every cell
// of MAX_ROWS by MAX_COLUMNS rounded up to powers of two, and shows busy. An
// init item takes the same sweep, one cell a cycle. A visit item marks walls
// on its cell and its sensed neighbors; then, for every cell taken from the
// flood queue other than the goal cell, it reads the walls and the open
// neighbors' distances and, when the cell is raised, queues its open
// neighbors; a final pick follows. A visit outside the grid answers the
// cycle after it is taken. Results are shown for one cycle on out_valid and
// cannot be stalled; the next item is taken once busy is low.
// Top level: config registers and clamping; uses mffs_pkg, mffs_ctrl,
// mffs_grid and mffs_queue.
module maze_floodfill_solver_top #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLUMNS = 16,
  parameter int QUEUE_DEPTH = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mffs_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mffs_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int CELLW = RW + CW;

  logic [4:0]    rows_r, cols_r;
  logic [3:0]    goal_row_r, goal_col_r;
  logic [RW:0]   rows_eff;
  logic [CW:0]   cols_eff;

  logic [CELLW-1:0] wall_ra, wall_wa, dist_ra, dist_wa, q_wdata, q_rdata;
  logic             wall_we, dist_we, q_empty, q_overflow;
  logic [3:0]       wall_wd, wall_q;
  logic [7:0]       dist_wd, dist_q;
  mffs_pkg::queue_cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= mffs_pkg::ROWS_RESET;
      cols_r     <= mffs_pkg::COLUMNS_RESET;
      goal_row_r <= mffs_pkg::GOAL_ROW_RESET;
      goal_col_r <= mffs_pkg::GOAL_COL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mffs_pkg::CFG_ROWS:     rows_r     <= cfg_data;
        mffs_pkg::CFG_COLUMNS:  cols_r     <= cfg_data;
        mffs_pkg::CFG_GOAL_ROW: goal_row_r <= cfg_data[3:0];
        mffs_pkg::CFG_GOAL_COL: goal_col_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Grid size in use is held to 1..MAX.
  always_comb begin
    if (rows_r == '0) rows_eff = (RW+1)'(1);
    else if (8'(rows_r) > 8'(MAX_ROWS)) rows_eff = (RW+1)'(MAX_ROWS);
    else rows_eff = (RW+1)'(rows_r);
    if (cols_r == '0) cols_eff = (CW+1)'(1);
    else if (8'(cols_r) > 8'(MAX_COLUMNS)) cols_eff = (CW+1)'(MAX_COLUMNS);
    else cols_eff = (CW+1)'(cols_r);
  end

  mffs_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_ctrl (
    .clk, .rst_n, .start, .in_item, .busy, .out_valid, .out_item,
    .rows_eff, .cols_eff, .goal_row(goal_row_r), .goal_col(goal_col_r),
    .wall_ra, .wall_we, .wall_wa, .wall_wd, .wall_q,
    .dist_ra, .dist_we, .dist_wa, .dist_wd, .dist_q,
    .q_cmd, .q_wdata, .q_rdata, .q_empty, .q_overflow
  );

  mffs_grid #(.CELLW(CELLW)) u_grid (
    .clk, .wall_ra, .wall_we, .wall_wa, .wall_wd, .wall_q,
    .dist_ra, .dist_we, .dist_wa, .dist_wd, .dist_q
  );

  mffs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .CELLW(CELLW)) u_queue (
    .clk, .rst_n, .cmd(q_cmd), .wdata(q_wdata), .rdata(q_rdata),
    .empty(q_empty), .overflow(q_overflow)
  );

endmodule

@@ src/mffs_checker.sv @@
// Port-level checks of the maze flood-fill solver, bound to its top level.
// Depends on mffs_pkg and maze_floodfill_solver_top.
module mffs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input mffs_pkg::out_item_t out_item
);

  // After reset the grid is rebuilt before any item is taken.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("item taken without work or result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // A cell with no distance only comes from an init or an off-grid visit.
  a_none_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.cell_distance == mffs_pkg::DIST_NONE |->
      out_item.next_direction == mffs_pkg::DIR_N && !out_item.queue_overflow)
    else $error("inconsistent empty result");

endmodule

bind maze_floodfill_solver_top mffs_checker u_mffs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
